FILE: rtl/core/ssfe_pkg.sv
// Shared types and codes for the SMBIOS string field extractor.
`timescale 1ns / 1ps
`default_nettype none

package ssfe_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_CHAR      = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_ABSENT    = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  // Configuration register indexes
  localparam logic CFG_TARGET_TYPE = 1'b0;
  localparam logic CFG_STRING_OFFSET = 1'b1;

  // Register reset values
  localparam logic [7:0] TARGET_TYPE_RESET = 8'd2;
  localparam logic [7:0] STRING_OFFSET_RESET = 8'd7;

  // One result from the parser step
  typedef struct packed {
    logic       valid;
    logic       char_valid;
    logic [7:0] char_byte;
    status_t    status;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/smbios_string_field_extractor.sv
// Top level of the SMBIOS string field extractor: config, stream ports, result register.
`timescale 1ns / 1ps
`default_nettype none

// Takes a raw SMBIOS structure table one byte per request on the slave stream
// (tlast on the table's final byte) and finds the first structure whose type
// matches target_type. The string number at string_index_offset in its
// formatted area selects a string, whose bytes come out one per request on the
// master stream, followed by a completion status; absent, not-found and
// truncated outcomes are reported the same way, with tlast on the final
// result of each search. Each byte is parsed in the cycle it is accepted and
// its result, if any, lands in a single output register, so one byte is
// taken every cycle while the master side keeps up; a stalled result holds
// the slave side only until it is taken. Configuration writes are meant for
// idle periods between tables.
module smbios_string_field_extractor (
  input  wire logic        clk,
  input  wire logic        rst,
  // Slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] table_byte
  input  wire logic        s_axis_tlast,   // table_last
  // Master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] char_byte, [10:8] status, rest zero
  output logic             m_axis_tuser,   // [0] char_valid
  output logic             m_axis_tlast,   // last
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import ssfe_pkg::*;

  logic [7:0] target_type;
  logic [7:0] string_index_offset;
  logic       in_fire;
  result_t    step_result;
  logic       out_valid;
  logic       out_char_valid;
  logic [7:0] out_char_byte;
  status_t    out_status;
  logic       out_last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_type         <= TARGET_TYPE_RESET;
      string_index_offset <= STRING_OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_TYPE:   target_type <= cfg_data;
        CFG_STRING_OFFSET: string_index_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept while the result register is empty or draining
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  ssfe_parser u_parser (
    .clk                 (clk),
    .rst                 (rst),
    .advance             (in_fire),
    .table_byte          (s_axis_tdata),
    .table_last          (s_axis_tlast),
    .target_type         (target_type),
    .string_index_offset (string_index_offset),
    .result              (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid <= in_fire && step_result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && step_result.valid) begin
      out_char_valid <= step_result.char_valid;
      out_char_byte  <= step_result.char_byte;
      out_status     <= step_result.status;
      out_last       <= step_result.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_status, out_char_byte};
  assign m_axis_tuser  = out_char_valid;
  assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire

FILE: rtl/core/ssfe_parser.sv
// Byte-wise SMBIOS structure parser: state registers and next-state logic.
`timescale 1ns / 1ps
`default_nettype none

module ssfe_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic [7:0]      table_byte,
  input  wire logic            table_last,
  input  wire logic [7:0]      target_type,
  input  wire logic [7:0]      string_index_offset,
  output ssfe_pkg::result_t    result
);
  import ssfe_pkg::*;

  typedef enum logic [1:0] {
    PH_FORMAT  = 2'b01,
    PH_STRINGS = 2'b10
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] struct_offset, struct_offset_next;
  logic [7:0] struct_type, struct_type_next;
  logic [7:0] formatted_length, formatted_length_next;
  logic [7:0] wanted_string, wanted_string_next;
  logic [7:0] string_count, string_count_next;
  logic       prev_was_nul, prev_was_nul_next;
  logic       emitting, emitting_next;
  logic       finished, finished_next;

  logic [7:0] count_inc;
  logic       is_target;
  logic       format_done;

  // Saturating string counter increment
  assign count_inc = (string_count == 8'hFF) ? 8'hFF : string_count + 8'd1;
  assign is_target = (struct_type == target_type);
  assign format_done = (struct_offset != 8'd0) &&
                       ({1'b0, struct_offset} + 9'd1 >= {1'b0, formatted_length_next});

  // Next state and result for the current byte
  always_comb begin
    phase_next            = phase;
    struct_offset_next    = struct_offset;
    struct_type_next      = struct_type;
    formatted_length_next = formatted_length;
    wanted_string_next    = wanted_string;
    string_count_next     = string_count;
    prev_was_nul_next     = prev_was_nul;
    emitting_next         = emitting;
    finished_next         = finished;
    result                = '{valid: 1'b0, char_valid: 1'b0, char_byte: 8'd0,
                              status: ST_CHAR, last: 1'b0};

    if (!finished) begin
      case (phase)
        PH_FORMAT: begin
          if (struct_offset == 8'd0) struct_type_next = table_byte;
          if (struct_offset == 8'd1) formatted_length_next = table_byte;
          if (struct_offset == string_index_offset) wanted_string_next = table_byte;
          if (format_done) begin
            phase_next        = PH_STRINGS;
            string_count_next = 8'd0;
            prev_was_nul_next = 1'b0;
            if (struct_type_next == target_type && wanted_string_next == 8'd0) begin
              result.valid  = 1'b1;
              result.status = ST_ABSENT;
              result.last   = 1'b1;
              finished_next = 1'b1;
            end
          end else begin
            struct_offset_next = struct_offset + 8'd1;
          end
        end
        PH_STRINGS: begin
          if (emitting) begin
            // Inside the selected string
            result.valid = 1'b1;
            if (table_byte == 8'd0) begin
              result.status = ST_COMPLETE;
              result.last   = 1'b1;
              emitting_next = 1'b0;
              finished_next = 1'b1;
            end else begin
              result.char_valid = 1'b1;
              result.char_byte  = table_byte;
              result.status     = table_last ? ST_TRUNCATED : ST_CHAR;
              result.last       = table_last;
            end
          end else if (table_byte == 8'd0) begin
            if (prev_was_nul) begin
              // Double NUL closes the structure
              if (is_target) begin
                result.valid  = 1'b1;
                result.status = ST_NOT_FOUND;
                result.last   = 1'b1;
                finished_next = 1'b1;
              end
              phase_next            = PH_FORMAT;
              struct_offset_next    = 8'd0;
              struct_type_next      = 8'd0;
              formatted_length_next = 8'd0;
              wanted_string_next    = 8'd0;
              string_count_next     = 8'd0;
              prev_was_nul_next     = 1'b0;
            end else begin
              prev_was_nul_next = 1'b1;
            end
          end else begin
            // First byte of a new string
            if (prev_was_nul || string_count == 8'd0) begin
              string_count_next = count_inc;
              if (is_target && count_inc == wanted_string) begin
                emitting_next     = 1'b1;
                result.valid      = 1'b1;
                result.char_valid = 1'b1;
                result.char_byte  = table_byte;
                result.status     = table_last ? ST_TRUNCATED : ST_CHAR;
                result.last       = table_last;
              end
            end
            prev_was_nul_next = 1'b0;
          end
        end
        default: begin
          phase_next = PH_FORMAT;
        end
      endcase
    end

    // Table end: report a miss and rearm
    if (table_last) begin
      if (!finished_next && !result.valid) begin
        result.valid  = 1'b1;
        result.status = ST_NOT_FOUND;
        result.last   = 1'b1;
      end
      phase_next            = PH_FORMAT;
      struct_offset_next    = 8'd0;
      struct_type_next      = 8'd0;
      formatted_length_next = 8'd0;
      wanted_string_next    = 8'd0;
      string_count_next     = 8'd0;
      prev_was_nul_next     = 1'b0;
      emitting_next         = 1'b0;
      finished_next         = 1'b0;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_FORMAT;
      struct_offset    <= 8'd0;
      struct_type      <= 8'd0;
      formatted_length <= 8'd0;
      wanted_string    <= 8'd0;
      string_count     <= 8'd0;
      prev_was_nul     <= 1'b0;
      emitting         <= 1'b0;
      finished         <= 1'b0;
    end else if (advance) begin
      phase            <= phase_next;
      struct_offset    <= struct_offset_next;
      struct_type      <= struct_type_next;
      formatted_length <= formatted_length_next;
      wanted_string    <= wanted_string_next;
      string_count     <= string_count_next;
      prev_was_nul     <= prev_was_nul_next;
      emitting         <= emitting_next;
      finished         <= finished_next;
    end
  end

endmodule

`default_nettype wire

FILE: sim/smbios_string_checker.sv
// Checker for the SMBIOS string extractor: watches both streams, predicts results, compares.
`timescale 1ns / 1ps

module smbios_string_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] table_byte
  input  logic        s_tlast,    // table_last
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,    // [7:0] char_byte, [10:8] status, rest zero
  input  logic        m_tuser,    // [0] char_valid
  input  logic        m_tlast,    // last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  import ssfe_pkg::*;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_byte;
    status_t    status;
    logic       last;
  } string_result_t;

  string_result_t string_results_due[$];

  // Register copies, as written through the config port
  logic [7:0] want_type;
  logic [7:0] want_offset;

  // Parser state
  bit         in_strings;
  logic [7:0] area_offset;
  logic [7:0] struct_type;
  logic [7:0] fmt_len;
  logic [7:0] wanted_num;
  logic [7:0] str_count;
  bit         prev_nul;
  bit         emitting;
  bit         done;

  function automatic string_result_t make_result(logic cv, logic [7:0] ch, status_t st,
                                                 logic lst);
    return '{cv, ch, st, lst};
  endfunction

  function automatic void clear_parse();
    in_strings  = 1'b0;
    area_offset = 8'd0;
    struct_type = 8'd0;
    fmt_len     = 8'd0;
    wanted_num  = 8'd0;
    str_count   = 8'd0;
    prev_nul    = 1'b0;
    emitting    = 1'b0;
    done        = 1'b0;
  endfunction

  // One table byte through the parser; queues the result it causes, if any
  function automatic void track_table_byte(input logic [7:0] b, input logic eot);
    string_result_t r;
    bit made;
    bit tgt;
    made = 1'b0;
    r = '0;
    if (!done) begin
      if (!in_strings) begin
        // formatted area
        if (area_offset == 8'd0) struct_type = b;
        if (area_offset == 8'd1) fmt_len = b;
        if (area_offset == want_offset) wanted_num = b;
        if (area_offset >= 8'd1 && int'(area_offset) + 1 >= int'(fmt_len)) begin
          in_strings = 1'b1;
          str_count = 8'd0;
          prev_nul = 1'b0;
          if (struct_type == want_type && wanted_num == 8'd0) begin
            r = make_result(1'b0, 8'h00, ST_ABSENT, 1'b1);
            made = 1'b1;
            done = 1'b1;
          end
        end else begin
          area_offset = area_offset + 8'd1;
        end
      end else begin
        // string area
        tgt = (struct_type == want_type);
        if (emitting) begin
          if (b == 8'h00) begin
            r = make_result(1'b0, 8'h00, ST_COMPLETE, 1'b1);
            emitting = 1'b0;
            done = 1'b1;
          end else if (eot) begin
            r = make_result(1'b1, b, ST_TRUNCATED, 1'b1);
          end else begin
            r = make_result(1'b1, b, ST_CHAR, 1'b0);
          end
          made = 1'b1;
        end else if (b == 8'h00) begin
          if (prev_nul) begin
            // double NUL closes the structure
            if (tgt) begin
              r = make_result(1'b0, 8'h00, ST_NOT_FOUND, 1'b1);
              made = 1'b1;
              done = 1'b1;
            end
            in_strings  = 1'b0;
            area_offset = 8'd0;
            struct_type = 8'd0;
            fmt_len     = 8'd0;
            wanted_num  = 8'd0;
            str_count   = 8'd0;
            prev_nul    = 1'b0;
          end else begin
            prev_nul = 1'b1;
          end
        end else begin
          if (prev_nul || str_count == 8'd0) begin
            if (str_count != 8'd255) str_count = str_count + 8'd1;
            if (tgt && str_count == wanted_num) begin
              emitting = 1'b1;
              r = eot ? make_result(1'b1, b, ST_TRUNCATED, 1'b1)
                      : make_result(1'b1, b, ST_CHAR, 1'b0);
              made = 1'b1;
            end
          end
          prev_nul = 1'b0;
        end
      end
    end
    // table end rearms the parser
    if (eot) begin
      if (!done && !made) begin
        r = make_result(1'b0, 8'h00, ST_NOT_FOUND, 1'b1);
        made = 1'b1;
      end
      clear_parse();
    end
    if (made) string_results_due.push_back(r);
  endfunction

  task automatic check_field(input string name, input logic [7:0] expv,
                             input logic [7:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected %0h, got %0h", name, expv, actv);
      fail_count++;
    end
  endtask

  // Compare taken results first, then predict from the byte taken at the same edge
  always @(posedge clk) begin : watch
    string_result_t want;
    if (rst) begin
      want_type   = TARGET_TYPE_RESET;
      want_offset = STRING_OFFSET_RESET;
      clear_parse();
      string_results_due.delete();
      fail_count  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (string_results_due.size() == 0) begin
          $error("unexpected result: tdata %0h tuser %0b tlast %0b", m_tdata, m_tuser, m_tlast);
          fail_count++;
        end else begin
          want = string_results_due.pop_front();
          check_field("char_valid", {7'd0, want.char_valid}, {7'd0, m_tuser});
          check_field("char_byte", want.char_byte, m_tdata[7:0]);
          check_field("status", {5'd0, want.status}, {5'd0, m_tdata[10:8]});
          check_field("last", {7'd0, want.last}, {7'd0, m_tlast});
          check_field("tdata padding", 8'd0, {3'd0, m_tdata[15:11]});
        end
      end
      if (s_tvalid && s_tready) track_table_byte(s_tdata, s_tlast);
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_TYPE:   want_type = cfg_data;
          CFG_STRING_OFFSET: want_offset = cfg_data;
          default: ;
        endcase
      end
    end
    pending = string_results_due.size();
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the SMBIOS string extractor: clock, reset, table stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import ssfe_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BYTES = 480;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = 8'd0;

  int fail_count;
  int pending;
  int cycles = 0;
  int hold_requests = 0;

  // Table under construction and the register values the block holds
  logic [7:0] tbl[$];
  logic [7:0] cur_type = TARGET_TYPE_RESET;
  logic [7:0] cur_off = STRING_OFFSET_RESET;
  bit         tx_calm;

  always #1 clk = ~clk;

  smbios_string_field_extractor u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  smbios_string_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Result side: random stalls, calm stretches, and a long hold-off on request
  initial begin : result_sink
    int stall_left;
    int calm_left;
    int served;
    int r;
    stall_left = 0;
    calm_left = 0;
    served = 0;
    forever begin
      @(negedge clk);
      if (served != hold_requests) begin
        served = hold_requests;
        stall_left = 200;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) calm_left = $urandom_range(50, 200);
          else if (r < 20) stall_left = $urandom_range(1, 3);
          else if (r < 22) stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  // One structure: formatted area of len bytes (at least two), then its strings
  function automatic void add_struct(input logic [7:0] typ, input logic [7:0] len,
                                     input logic [7:0] want, input int nstr,
                                     input int minlen, input int maxlen);
    int fa_end;
    int k;
    int n;
    fa_end = (len < 2) ? 1 : int'(len) - 1;
    tbl.push_back(typ);
    tbl.push_back(len);
    for (k = 2; k <= fa_end; k++)
      tbl.push_back((k == int'(cur_off)) ? want : 8'($urandom_range(0, 255)));
    if (nstr == 0) begin
      tbl.push_back(8'h00);
    end else begin
      for (k = 0; k < nstr; k++) begin
        n = $urandom_range(minlen, maxlen);
        repeat (n) tbl.push_back(8'($urandom_range(1, 255)));
        tbl.push_back(8'h00);
      end
    end
    tbl.push_back(8'h00);
  endfunction

  function automatic void trim_table(input int n);
    while (tbl.size() > n) void'(tbl.pop_back());
  endfunction

  // Mostly well-formed tables with random content, some noise and cut-off tables
  function automatic void build_random_table();
    int ns;
    int n;
    int r;
    int hi;
    int len;
    int nstr;
    logic [7:0] typ;
    logic [7:0] want;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 30);
      repeat (n) tbl.push_back(($urandom_range(0, 9) < 4) ? 8'h00 : 8'($urandom_range(0, 255)));
    end else begin
      ns = $urandom_range(1, 4);
      repeat (ns) begin
        typ = $urandom_range(0, 1) ? cur_type : 8'($urandom_range(0, 255));
        hi = (cur_off > 16) ? 20 : int'(cur_off) + 4;
        r = $urandom_range(0, 9);
        if (r == 0) len = $urandom_range(0, 1);
        else if (r < 3 || cur_off > 16 || cur_off < 2) len = $urandom_range(2, hi);
        else len = $urandom_range(int'(cur_off) + 1, hi);
        nstr = $urandom_range(0, 4);
        want = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, nstr + 1));
        add_struct(typ, 8'(len), want, nstr, 1, 8);
      end
    end
    if ($urandom_range(0, 5) == 0) trim_table($urandom_range(1, tbl.size()));
  endfunction

  // Offer one byte and wait for it to be taken; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    int r;
    gap = 0;
    if (!tx_calm) begin
      r = $urandom_range(0, 99);
      if (r >= 96) gap = $urandom_range(8, 30);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_table();
    int i;
    tx_calm = ($urandom_range(0, 3) == 0);
    for (i = 0; i < tbl.size(); i++) send_byte(tbl[i], i == tbl.size() - 1);
    tbl.delete();
  endtask

  // Stop offering and let every outstanding result drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] tt, input logic [7:0] off);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TARGET_TYPE;
    cfg_data  <= tt;
    @(negedge clk);
    cfg_index <= CFG_STRING_OFFSET;
    cfg_data  <= off;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_type = tt;
    cur_off = off;
  endtask

  initial begin : stimulus
    int random_bytes;
    int r;
    logic [7:0] tt;
    logic [7:0] oo;
    random_bytes = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed tables on the reset settings (type 2, offset 7)
    // second string of the first matching structure; later match ignored
    add_struct(8'd1, 8'd8, 8'd1, 2, 1, 6);
    add_struct(8'd2, 8'd8, 8'd2, 3, 1, 6);
    add_struct(8'd2, 8'd8, 8'd1, 1, 1, 4);
    send_table();
    // string number zero
    add_struct(8'd2, 8'd8, 8'd0, 2, 1, 4);
    add_struct(8'd9, 8'd4, 8'd0, 0, 1, 1);
    send_table();
    // structure too short to hold the number
    add_struct(8'd2, 8'd6, 8'd1, 2, 1, 4);
    send_table();
    // number beyond the last string
    add_struct(8'd2, 8'd8, 8'd5, 2, 1, 4);
    add_struct(8'd7, 8'd5, 8'd0, 1, 1, 3);
    send_table();
    // no matching structure at all
    add_struct(8'd1, 8'd8, 8'd1, 2, 1, 4);
    add_struct(8'd3, 8'd4, 8'd0, 0, 1, 1);
    send_table();
    // table cut in the middle of the selected string
    add_struct(8'd2, 8'd8, 8'd1, 1, 12, 12);
    trim_table(15);
    send_table();
    // formatted lengths of 0 and 1, then a one-byte-length target
    add_struct(8'd4, 8'd0, 8'd0, 1, 1, 3);
    add_struct(8'd5, 8'd1, 8'd0, 0, 1, 1);
    add_struct(8'd2, 8'd1, 8'd0, 1, 1, 3);
    send_table();
    // structure without strings before the target
    add_struct(8'd6, 8'd4, 8'd0, 0, 1, 1);
    add_struct(8'd2, 8'd9, 8'd3, 3, 1, 5);
    send_table();
    // extreme character values
    tbl = '{8'd2, 8'd8, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00, 8'd1,
            8'h01, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h00, 8'h00};
    send_table();
    // one-byte table
    tbl.push_back(8'hFF);
    send_table();
    // table ends on the target's last formatted byte with number zero
    add_struct(8'd2, 8'd8, 8'd0, 0, 1, 1);
    trim_table(8);
    send_table();
    // table ends on the first character of the selected string
    add_struct(8'd2, 8'd8, 8'd1, 1, 3, 3);
    trim_table(9);
    send_table();
    // long string while the result side holds off
    hold_requests++;
    add_struct(8'd2, 8'd8, 8'd1, 1, 40, 40);
    send_table();

    // Offsets below 4 pick up the type, length or handle byte
    wait_idle();
    set_config(8'd0, 8'd2);
    add_struct(8'd0, 8'd4, 8'd1, 2, 1, 5);
    send_table();
    wait_idle();
    set_config(8'd5, 8'd0);
    add_struct(8'd5, 8'd6, 8'd0, 6, 1, 3);
    send_table();
    wait_idle();
    set_config(8'd3, 8'd1);
    add_struct(8'd3, 8'd3, 8'd0, 3, 1, 3);
    send_table();
    wait_idle();
    set_config(8'd3, 8'd3);
    add_struct(8'd3, 8'd6, 8'd2, 2, 1, 3);
    send_table();
    // widest offset can never be reached
    wait_idle();
    set_config(8'd255, 8'd255);
    add_struct(8'd255, 8'd20, 8'd0, 2, 1, 3);
    send_table();

    // Random tables, settings changed now and then between tables
    while (random_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) begin
        wait_idle();
        r = $urandom_range(0, 5);
        case (r)
          0: tt = 8'd0;
          1: tt = 8'd255;
          2: tt = 8'd2;
          3: tt = 8'd128;
          default: tt = 8'($urandom_range(0, 255));
        endcase
        r = $urandom_range(0, 19);
        if (r == 0) oo = 8'd255;
        else if (r == 1) oo = 8'($urandom_range(0, 3));
        else if (r == 2) oo = 8'd4;
        else oo = 8'($urandom_range(4, 12));
        set_config(tt, oo);
      end
      build_random_table();
      random_bytes += tbl.size();
      send_table();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: smbios_string_field_extractor.f
rtl/core/ssfe_pkg.sv
rtl/core/ssfe_parser.sv
rtl/core/smbios_string_field_extractor.sv
sim/smbios_string_checker.sv
sim/tb_top.sv
